FILE: hw/rtl/acsa_pkg.sv
package acsa_pkg;

    localparam int CHANNELS_DEF = 12;
    localparam int WINDOW_DEF   = 8;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 4;
    localparam int MUX_W    = 8;
    localparam int SWEEP_W  = 32;
    localparam int NEG_W    = 4;

    localparam logic [NEG_W-1:0] NEG_RESET = 4'hC;

    // input item modes
    localparam logic MODE_READY = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // queued operations
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } acsa_op_t;

    typedef struct packed {
        logic     valid;
        acsa_op_t entry;
    } acsa_push_t;

    typedef struct packed {
        logic clearing;
        logic q_full;
    } acsa_front_status_t;

endpackage

FILE: hw/rtl/acsa_ram.sv
module acsa_ram
    import acsa_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/acsa_front.sv
module acsa_front
    import acsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    output logic                evt_ready,
    input  logic                mode,
    input  logic [SAMPLE_W-1:0] sample,
    input  acsa_front_status_t  status,
    output acsa_push_t          push
);

    logic awaiting_reg, awaiting_next;
    logic settled_reg, settled_next;
    logic accept;

    assign evt_ready = !status.clearing && !status.q_full;
    assign accept    = evt_valid && evt_ready;

    always_comb
    begin
        awaiting_next       = awaiting_reg;
        settled_next        = settled_reg;
        push.valid          = 1'b0;
        push.entry.op       = OP_READ;
        push.entry.sample   = sample;
        if (accept)
        begin
            if (mode == MODE_READY)
            begin
                if (!awaiting_reg)
                begin
                    if (!settled_reg)
                    begin
                        // first data ready after a switch is thrown away
                        settled_next = 1'b1;
                    end
                    else
                    begin
                        awaiting_next = 1'b1;
                        push.valid    = 1'b1;
                        push.entry.op = OP_READ;
                    end
                end
            end
            else if (awaiting_reg && settled_reg)
            begin
                awaiting_next = 1'b0;
                settled_next  = 1'b0;
                push.valid    = 1'b1;
                push.entry.op = OP_STORE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            settled_reg  <= 1'b0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            settled_reg  <= settled_next;
        end
    end

    a_await_settled: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> settled_reg)
        else $error("awaiting data without a settled multiplexer");

endmodule

FILE: hw/rtl/acsa_queue.sv
module acsa_queue
    import acsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  acsa_push_t push,
    output logic       full,
    output logic       head_valid,
    output acsa_op_t   head,
    input  logic       pop
);

    acsa_op_t        ent_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == QC_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

FILE: hw/rtl/acsa_back.sv
module acsa_back
    import acsa_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  acsa_op_t            q_head,
    output logic                q_pop,
    input  logic [NEG_W-1:0]    neg_input,
    output logic                clearing,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                kind,
    output logic [CHAN_W-1:0]   channel,
    output logic [SAMPLE_W-1:0] average,
    output logic [MUX_W-1:0]    mux_byte,
    output logic [SWEEP_W-1:0]  sweep_count
);

    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_W + LOG_W;
    // floor(s / WINDOW) = (s * RECIP) >> SHIFT, exact for every s below 2**SUM_W
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam longint RECIP_L =
        ((longint'(1) <<< SHIFT) + longint'(WINDOW) - 64'sd1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SWEEP_W-1:0]  sweeps_reg, sweeps_next;
    logic [SUM_W-1:0]    sum_reg [CHANNELS];
    logic                sum_we;
    logic [SUM_W-1:0]    sum_new;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [ADDR_W-1:0]   addr_hold_reg, addr_hold_next;
    logic [CH_W-1:0]     chan_hold_reg, chan_hold_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                res_valid_reg, res_valid_next;
    logic                kind_reg, kind_next;
    logic [CHAN_W-1:0]   channel_reg, channel_next;
    logic [SAMPLE_W-1:0] average_reg, average_next;
    logic [MUX_W-1:0]    mux_byte_reg, mux_byte_next;
    logic [SWEEP_W-1:0]  sweep_count_reg, sweep_count_next;

    logic                out_free;
    logic                emit;
    logic [ADDR_W-1:0]   cur_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;

    acsa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    assign out_free = !res_valid_reg || res_ready;
    assign cur_addr = ADDR_W'(int'(ch_reg) * WINDOW + int'(pos_reg));
    assign clearing = (state_reg == ST_CLEAR);
    assign sum_new  = sum_reg[ch_reg] - SUM_W'(ram_rdata) + SUM_W'(sample_reg);

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        ch_next          = ch_reg;
        pos_next         = pos_reg;
        sweeps_next      = sweeps_reg;
        sum_we           = 1'b0;
        sample_next      = sample_reg;
        addr_hold_next   = addr_hold_reg;
        chan_hold_next   = chan_hold_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;
        kind_next        = kind_reg;
        channel_next     = channel_reg;
        average_next     = average_reg;
        mux_byte_next    = mux_byte_reg;
        sweep_count_next = sweep_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_hold_reg;
        ram_wdata        = sample_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_head.op == OP_READ)
                    begin
                        if (out_free)
                        begin
                            q_pop            = 1'b1;
                            emit             = 1'b1;
                            kind_next        = KIND_READ;
                            channel_next     = '0;
                            average_next     = '0;
                            mux_byte_next    = '0;
                            sweep_count_next = sweeps_reg;
                        end
                    end
                    else
                    begin
                        // history entry is read at cur_addr this cycle
                        q_pop          = 1'b1;
                        sample_next    = q_head.sample;
                        addr_hold_next = cur_addr;
                        chan_hold_next = ch_reg;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_we   = 1'b1;
                sum_we   = 1'b1;
                acc_next = sum_new;
                if (int'(ch_reg) == CHANNELS - 1)
                begin
                    ch_next     = '0;
                    sweeps_next = sweeps_reg + 1'b1;
                    pos_next    = (int'(pos_reg) == WINDOW - 1) ? '0 : pos_reg + 1'b1;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'(RECIP);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    kind_next        = KIND_STORE;
                    channel_next     = CHAN_W'(chan_hold_reg);
                    average_next     = prod_reg[SHIFT +: SAMPLE_W];
                    mux_byte_next    = {CHAN_W'(ch_reg), neg_input};
                    sweep_count_next = sweeps_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            ch_reg        <= '0;
            pos_reg       <= '0;
            sweeps_reg    <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ch_reg        <= ch_next;
            pos_reg       <= pos_next;
            sweeps_reg    <= sweeps_next;
            res_valid_reg <= res_valid_next;
            if (sum_we)
            begin
                sum_reg[ch_reg] <= sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        addr_hold_reg   <= addr_hold_next;
        chan_hold_reg   <= chan_hold_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        kind_reg        <= kind_next;
        channel_reg     <= channel_next;
        average_reg     <= average_next;
        mux_byte_reg    <= mux_byte_next;
        sweep_count_reg <= sweep_count_next;
    end

    assign res_valid   = res_valid_reg;
    assign kind        = kind_reg;
    assign channel     = channel_reg;
    assign average     = average_reg;
    assign mux_byte    = mux_byte_reg;
    assign sweep_count = sweep_count_reg;

    a_read_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_MUL))
        else $error("history update did not move on to the multiply");

    a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !res_valid_reg)
        else $error("result shown during history clear");

    a_store_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid && q_head.op == OP_STORE) |=>
            (state_reg == ST_READ))
        else $error("store item not taken into the read step");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ch_reg) < CHANNELS)
        else $error("scan index out of range");

endmodule

FILE: hw/rtl/adc_channel_scan_averager_core.sv
// Round-robin ADC scan sequencer with a per-channel boxcar average.
// Event channel (evt_valid/evt_ready, mode, sample): mode 0 is a data-ready
// event, mode 1 carries the read data. Items that the scan does not expect
// are swallowed with no result.
// Result channel (res_valid/res_ready): kind 0 asks for a read-data command
// and carries the current sweep count; kind 1 reports the stored channel,
// its new average, the next multiplexer byte and the sweep count.
// Config channel (cfg_valid/cfg_ready, negative_input) is always ready and
// sets the low nibble of the multiplexer byte; write it only while idle.
// A read request passes from the queue to the output register; a stored
// sample passes through the queue, history read, sum update, reciprocal
// multiply and output register. An item can be taken every cycle while the
// two-entry queue has room; a stored sample holds the back end through its
// read, multiply and output states, a read request only until it is emitted.
// After reset the history memory is cleared, one entry a cycle, all
// CHANNELS*WINDOW entries (96 by default); evt_ready stays low meanwhile.
// A stalled receiver holds the result in its output register; the queue
// then fills and evt_ready drops.
module adc_channel_scan_averager_core
    import acsa_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    output logic                evt_ready,
    input  logic                mode,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                kind,
    output logic [CHAN_W-1:0]   channel,
    output logic [SAMPLE_W-1:0] average,
    output logic [MUX_W-1:0]    mux_byte,
    output logic [SWEEP_W-1:0]  sweep_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NEG_W-1:0]    negative_input
);

    logic [NEG_W-1:0]   neg_reg;
    acsa_push_t         push;
    acsa_front_status_t front_status;
    logic               q_full;
    logic               q_valid;
    acsa_op_t           q_head;
    logic               q_pop;
    logic               clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= NEG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            neg_reg <= negative_input;
        end
    end

    assign front_status.clearing = clearing;
    assign front_status.q_full   = q_full;

    acsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .mode      (mode),
        .sample    (sample),
        .status    (front_status),
        .push      (push)
    );

    acsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    acsa_back #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .neg_input   (neg_reg),
        .clearing    (clearing),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .channel     (channel),
        .average     (average),
        .mux_byte    (mux_byte),
        .sweep_count (sweep_count)
    );

endmodule

FILE: bench/adc_channel_scan_averager_core_test.sv
`timescale 1ns / 1ps

module adc_channel_scan_averager_core_test;
    import acsa_pkg::*;

    localparam int CHANNELS = CHANNELS_DEF;
    localparam int WINDOW   = WINDOW_DEF;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 16;
    localparam int LONG_STALL    = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int PRINT_CAP     = 50;

    typedef struct {
        logic                kind;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] average;
        logic [MUX_W-1:0]    mux_byte;
        logic [SWEEP_W-1:0]  sweep_count;
    } scan_result_t;

    logic                clk;
    logic                rst_n;
    logic                evt_valid;
    logic                evt_ready;
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic                res_valid;
    logic                res_ready;
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] average;
    logic [MUX_W-1:0]    mux_byte;
    logic [SWEEP_W-1:0]  sweep_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [NEG_W-1:0]    negative_input;

    // predicted scan state
    logic [NEG_W-1:0]    neg_code;
    logic                data_pending;
    logic                mux_ready;
    int unsigned         scan_pos;
    logic [SWEEP_W-1:0]  sweep_total;
    int unsigned         hist_slot;
    logic [SAMPLE_W-1:0] hist_mem [CHANNELS][WINDOW];
    logic [18:0]         chan_sum [CHANNELS];

    scan_result_t expected_results[$];
    int unsigned  errors;
    logic         steady_src;
    logic         steady_sink;
    logic         stall_request;
    logic         stall_active;

    adc_channel_scan_averager_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .mode           (mode),
        .sample         (sample),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .kind           (kind),
        .channel        (channel),
        .average        (average),
        .mux_byte       (mux_byte),
        .sweep_count    (sweep_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .negative_input (negative_input)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic void reset_scan_model();
        neg_code     = NEG_RESET;
        data_pending = 1'b0;
        mux_ready    = 1'b0;
        scan_pos     = 0;
        sweep_total  = '0;
        hist_slot    = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_sum[c] = '0;
            for (int w = 0; w < WINDOW; w++)
                hist_mem[c][w] = '0;
        end
    endfunction

    function automatic void predict_scan(input logic m, input logic [SAMPLE_W-1:0] s);
        scan_result_t r;
        int unsigned  ch;
        int unsigned  nxt;
        r.kind        = KIND_READ;
        r.channel     = '0;
        r.average     = '0;
        r.mux_byte    = '0;
        r.sweep_count = sweep_total;
        if (m == MODE_READY)
        begin
            if (data_pending)
                return;
            if (!mux_ready)
            begin
                mux_ready = 1'b1;
                return;
            end
            data_pending = 1'b1;
            expected_results.push_back(r);
            return;
        end
        if (!data_pending || !mux_ready)
            return;
        ch = scan_pos % CHANNELS;
        // 19-bit wrap in the middle is harmless, the final sum is never negative
        chan_sum[ch] = chan_sum[ch] - 19'(hist_mem[ch][hist_slot]) + 19'(s);
        hist_mem[ch][hist_slot] = s;
        nxt = ch + 1;
        if (nxt >= CHANNELS)
        begin
            nxt         = 0;
            sweep_total = sweep_total + 1;
            hist_slot   = (hist_slot + 1) % WINDOW;
        end
        scan_pos     = nxt;
        data_pending = 1'b0;
        mux_ready    = 1'b0;
        r.kind        = KIND_STORE;
        r.channel     = CHAN_W'(ch);
        r.average     = SAMPLE_W'(chan_sum[ch] / WINDOW);
        r.mux_byte    = {4'(nxt), neg_code};
        r.sweep_count = sweep_total;
        expected_results.push_back(r);
    endfunction

    // mostly no gap or a short one, now and then a long one
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // caller must follow up in the same step (another item or a drain),
    // otherwise the accepted item would be offered twice
    task automatic send_event(input logic m, input logic [SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = steady_src ? 0 : gap_cycles();
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        mode      <= m;
        sample    <= s;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        predict_scan(m, s);
    endtask

    // settle, request, data: one full conversion
    task automatic convert(input logic [SAMPLE_W-1:0] s);
        send_event(MODE_READY, SAMPLE_W'($urandom));
        send_event(MODE_READY, SAMPLE_W'($urandom));
        send_event(MODE_DATA, s);
    endtask

    task automatic wait_drained();
        evt_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_negative(input logic [NEG_W-1:0] v);
        wait_drained();
        // swallowed items leave nothing in the queue to wait on
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid      <= 1'b1;
        negative_input <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        neg_code = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_event(MODE_DATA, '1);           // data before any request
        send_event(MODE_READY, '0);          // settling event
        send_event(MODE_DATA, 16'h1234);     // settled but no read asked
        send_event(MODE_READY, '1);          // read request
        send_event(MODE_READY, '0);          // already awaiting data
        send_event(MODE_DATA, '1);
        send_event(MODE_DATA, '0);           // data after the switch
        convert('0);
        convert(16'h8000);
        convert('1);
        convert(16'h7FFF);
        wait_drained();
    endtask

    task automatic test_config_values();
        logic [NEG_W-1:0] codes [4];
        codes = '{4'h0, 4'hF, 4'hA, 4'h5};
        foreach (codes[i])
        begin
            write_negative(codes[i]);
            repeat (CHANNELS) convert(pick_sample());
            wait_drained();
        end
    endtask

    task automatic test_random();
        int unsigned done_items;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_negative(NEG_W'($urandom_range(0, 15)));
            steady_src  = ($urandom_range(0, 3) == 0);
            steady_sink = ($urandom_range(0, 3) == 0);
            done_items  = 0;
            while (done_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    convert(pick_sample());
                    done_items += 3;
                end
                else
                begin
                    send_event(logic'($urandom_range(0, 1)), pick_sample());
                    done_items++;
                end
            end
            wait_drained();
        end
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    task automatic test_backpressure();
        stall_request = 1'b1;
        // offer items only once the sink is really holding off
        wait (stall_active === 1'b1);
        steady_src    = 1'b1;
        repeat (10) convert(pick_sample());
        steady_src = 1'b0;
        wait_drained();
        while (stall_request)
            @(posedge clk);
    endtask

    task automatic test_drain_pause();
        repeat (4)
        begin
            repeat ($urandom_range(1, 6)) convert(pick_sample());
            send_event(MODE_READY, pick_sample());
            wait_drained();
        end
    endtask

    // result sink: random ready pattern, plus a long hold-off on request
    initial
    begin : result_sink
        int unsigned span;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                res_ready <= 1'b0;
                stall_active = 1'b1;
                repeat (LONG_STALL) @(posedge clk);
                stall_active  = 1'b0;
                stall_request = 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge clk);
                span = steady_sink ? 0 : gap_cycles();
                if (span > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : result_check
        scan_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(kind), 32'(want.kind));
                    check_field("channel", 32'(channel), 32'(want.channel));
                    check_field("average", 32'(average), 32'(want.average));
                    check_field("mux_byte", 32'(mux_byte), 32'(want.mux_byte));
                    check_field("sweep_count", sweep_count, want.sweep_count);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((evt_valid && evt_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : sequencer
        rst_n          = 1'b0;
        evt_valid      = 1'b0;
        mode           = MODE_READY;
        sample         = '0;
        cfg_valid      = 1'b0;
        negative_input = NEG_RESET;
        errors         = 0;
        steady_src     = 1'b0;
        steady_sink    = 1'b0;
        stall_request  = 1'b0;
        stall_active   = 1'b0;
        reset_scan_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_values();
        test_random();
        test_backpressure();
        test_drain_pause();
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
